/* design/iq_frame_row_demux_assert.svh */
`ifndef IQ_FRAME_ROW_DEMUX_ASSERT_SVH
`define IQ_FRAME_ROW_DEMUX_ASSERT_SVH

// same-cycle implication, checked on clk, off during reset
`define IQFRD_ASSERT_NOW(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication, checked on clk, off during reset
`define IQFRD_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

/* design/iqfrd_pkg.sv */
package iqfrd_pkg;

    localparam int BUFFER_BYTES   = 16777216;
    localparam int MAX_ROW_BYTES  = 4096;
    localparam int PAYLOAD_OFFSET = 17;

    localparam int ADDR_W  = 24;
    localparam int LEN_W   = 13;
    localparam int POS_W   = 5;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 16;

    localparam int LEN_MAX = (MAX_ROW_BYTES < BUFFER_BYTES) ? MAX_ROW_BYTES : BUFFER_BYTES;

    localparam logic [POS_W-1:0] COUNT_HI_POS = POS_W'(14);
    localparam logic [POS_W-1:0] COUNT_LO_POS = POS_W'(15);
    localparam logic [POS_W-1:0] CHANNEL_POS  = POS_W'(16);
    localparam logic [POS_W-1:0] PAYLOAD_POS  = POS_W'(PAYLOAD_OFFSET);

    localparam logic [BYTE_W-1:0] CHAN_CODE_Q = BYTE_W'(1);
    localparam logic [BYTE_W-1:0] CHAN_CODE_I = BYTE_W'(16);

    localparam logic [LEN_W-1:0] ROW_LENGTH_RESET = LEN_W'(1024);
    localparam logic [LEN_W-1:0] ROW_COUNT_RESET  = LEN_W'(1);

    localparam logic CFG_ROW_LENGTH = 1'b0;
    localparam logic CFG_ROW_COUNT  = 1'b1;

    localparam int DIV_W     = $clog2(BUFFER_BYTES) + 1;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam logic [DIV_W-1:0] FIT_RESET =
        DIV_W'(BUFFER_BYTES / 1024);

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic EVT_WRITE = 1'b0;
    localparam logic EVT_ERROR = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic              packet_start;
        logic [BYTE_W-1:0] byte_value;
    } in_item_t;

    typedef struct packed {
        logic              event_kind;
        logic              buffer_select;
        logic [ADDR_W-1:0] write_address;
        logic [BYTE_W-1:0] data_value;
        logic              capture_done;
    } out_item_t;

    typedef enum logic [2:0] {
        CMD_START    = 3'd0,
        CMD_FRAME    = 3'd1,
        CMD_COUNT_HI = 3'd2,
        CMD_COUNT_LO = 3'd3,
        CMD_CHANNEL  = 3'd4,
        CMD_PAYLOAD  = 3'd5
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [BYTE_W-1:0] byte_value;
    } cmd_t;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] rows;
        logic             busy;
    } limits_t;

endpackage

/* design/iqfrd_limits.sv */
module iqfrd_limits (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_en,
    input  logic                           cfg_index,
    input  logic [iqfrd_pkg::LEN_W-1:0]    cfg_data,
    output iqfrd_pkg::limits_t             lim
);

    logic [iqfrd_pkg::LEN_W-1:0]     row_length_reg;
    logic [iqfrd_pkg::LEN_W-1:0]     row_count_reg;
    logic                            busy_reg;
    logic [iqfrd_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [iqfrd_pkg::DIV_W-1:0]     dvd_reg;
    logic [iqfrd_pkg::LEN_W-1:0]     rem_reg;
    logic [iqfrd_pkg::DIV_W-1:0]     quo_reg;

    logic [iqfrd_pkg::LEN_W-1:0]     len_eff;
    logic [iqfrd_pkg::LEN_W-1:0]     rc_eff;
    logic [iqfrd_pkg::LEN_W:0]       trial;
    logic                            ge;
    logic [iqfrd_pkg::LEN_W:0]       diff;
    logic [iqfrd_pkg::LEN_W-1:0]     rem_next;
    logic [iqfrd_pkg::DIV_W-1:0]     quo_next;

    always_comb
    begin
        if (row_length_reg == '0)
        begin
            len_eff = iqfrd_pkg::LEN_W'(1);
        end
        else if (row_length_reg > iqfrd_pkg::LEN_W'(iqfrd_pkg::LEN_MAX))
        begin
            len_eff = iqfrd_pkg::LEN_W'(iqfrd_pkg::LEN_MAX);
        end
        else
        begin
            len_eff = row_length_reg;
        end
        rc_eff = (row_count_reg == '0) ? iqfrd_pkg::LEN_W'(1) : row_count_reg;
    end

    // one quotient bit of BUFFER_BYTES / row length per cycle
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[iqfrd_pkg::DIV_W-1]};
        ge       = (trial >= {1'b0, len_eff});
        diff     = trial - {1'b0, len_eff};
        rem_next = ge ? diff[iqfrd_pkg::LEN_W-1:0] : trial[iqfrd_pkg::LEN_W-1:0];
        quo_next = {quo_reg[iqfrd_pkg::DIV_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_length_reg <= iqfrd_pkg::ROW_LENGTH_RESET;
            row_count_reg  <= iqfrd_pkg::ROW_COUNT_RESET;
            busy_reg       <= 1'b0;
            cnt_reg        <= '0;
            dvd_reg        <= '0;
            rem_reg        <= '0;
            quo_reg        <= iqfrd_pkg::FIT_RESET;
        end
        else
        begin
            if (cfg_en)
            begin
                if (cfg_index == iqfrd_pkg::CFG_ROW_LENGTH)
                begin
                    row_length_reg <= cfg_data;
                end
                else
                begin
                    row_count_reg <= cfg_data;
                end
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                dvd_reg  <= iqfrd_pkg::DIV_W'(iqfrd_pkg::BUFFER_BYTES);
                rem_reg  <= '0;
                quo_reg  <= '0;
            end
            else if (busy_reg)
            begin
                dvd_reg <= {dvd_reg[iqfrd_pkg::DIV_W-2:0], 1'b0};
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg + iqfrd_pkg::DIV_CNT_W'(1);
                if (cnt_reg == iqfrd_pkg::DIV_CNT_W'(iqfrd_pkg::DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        lim.len  = len_eff;
        lim.busy = busy_reg;
        if (quo_reg < iqfrd_pkg::DIV_W'(rc_eff))
        begin
            lim.rows = quo_reg[iqfrd_pkg::LEN_W-1:0];
        end
        else
        begin
            lim.rows = rc_eff;
        end
    end

endmodule

/* design/iqfrd_front.sv */
module iqfrd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  iqfrd_pkg::in_item_t in_data,
    input  logic                q_full,
    output logic                in_ready,
    output logic                push,
    output iqfrd_pkg::cmd_t     push_cmd
);

    logic [iqfrd_pkg::POS_W-1:0] pos_reg;
    logic [iqfrd_pkg::POS_W-1:0] pos_next;
    logic [iqfrd_pkg::POS_W-1:0] pos;
    logic                        accept;
    logic                        keep;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        pos = in_data.packet_start ? '0 : pos_reg;
        if (pos >= iqfrd_pkg::PAYLOAD_POS)
        begin
            pos_next = iqfrd_pkg::PAYLOAD_POS;
        end
        else
        begin
            pos_next = pos + iqfrd_pkg::POS_W'(1);
        end

        keep                = 1'b1;
        push_cmd.byte_value = in_data.byte_value;
        push_cmd.kind       = iqfrd_pkg::CMD_FRAME;
        if (in_data.opcode)
        begin
            push_cmd.kind = iqfrd_pkg::CMD_START;
            pos_next      = iqfrd_pkg::PAYLOAD_POS;
        end
        else if (pos == iqfrd_pkg::COUNT_HI_POS)
        begin
            push_cmd.kind = iqfrd_pkg::CMD_COUNT_HI;
        end
        else if (pos == iqfrd_pkg::COUNT_LO_POS)
        begin
            push_cmd.kind = iqfrd_pkg::CMD_COUNT_LO;
        end
        else if (pos == iqfrd_pkg::CHANNEL_POS)
        begin
            push_cmd.kind = iqfrd_pkg::CMD_CHANNEL;
        end
        else if (pos == iqfrd_pkg::PAYLOAD_POS)
        begin
            push_cmd.kind = iqfrd_pkg::CMD_PAYLOAD;
        end
        else
        begin
            // drop header bytes; keep only the frame start marker
            keep = in_data.packet_start;
        end
    end

    assign push = accept && keep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

/* design/iqfrd_queue.sv */
module iqfrd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  iqfrd_pkg::cmd_t push_cmd,
    input  logic            pop_ready,
    output logic            full,
    output logic            cmd_valid,
    output iqfrd_pkg::cmd_t cmd
);

    iqfrd_pkg::cmd_t               slot_reg [iqfrd_pkg::Q_DEPTH];
    logic [iqfrd_pkg::Q_PTR_W-1:0] wr_ptr_reg;
    logic [iqfrd_pkg::Q_PTR_W-1:0] rd_ptr_reg;
    logic [iqfrd_pkg::Q_CNT_W-1:0] cnt_reg;
    logic                          pop;

    assign full      = (cnt_reg == iqfrd_pkg::Q_CNT_W'(iqfrd_pkg::Q_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign pop       = cmd_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + iqfrd_pkg::Q_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + iqfrd_pkg::Q_PTR_W'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + iqfrd_pkg::Q_CNT_W'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - iqfrd_pkg::Q_CNT_W'(1);
            end
        end
    end

endmodule

/* design/iqfrd_back.sv */
module iqfrd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  iqfrd_pkg::cmd_t      cmd,
    input  iqfrd_pkg::limits_t   lim,
    input  logic                 out_ready,
    output logic                 cmd_ready,
    output logic                 out_valid,
    output iqfrd_pkg::out_item_t out_data
);

    logic [iqfrd_pkg::BYTE_W-1:0]  latch_reg,    latch_next;
    logic [iqfrd_pkg::COUNT_W-1:0] exp_reg,      exp_next;
    logic                          init_reg,     init_next;
    logic                          accepted_reg, accepted_next;
    logic                          chan_reg,     chan_next;
    logic                          active_reg,   active_next;
    logic [iqfrd_pkg::LEN_W-1:0]   fill_reg      [2];
    logic [iqfrd_pkg::LEN_W-1:0]   fill_next     [2];
    logic [iqfrd_pkg::ADDR_W-1:0]  base_reg      [2];
    logic [iqfrd_pkg::ADDR_W-1:0]  base_next     [2];
    logic [iqfrd_pkg::LEN_W-1:0]   rows_done_reg [2];
    logic [iqfrd_pkg::LEN_W-1:0]   rows_done_next[2];
    logic                          out_valid_reg, out_valid_next;
    iqfrd_pkg::out_item_t          out_data_reg,  out_data_next;

    logic                          take;
    logic                          res_valid;
    logic                          c;
    logic [iqfrd_pkg::COUNT_W-1:0] cnt;
    logic                          q_ok;
    logic                          i_ok;
    logic [iqfrd_pkg::LEN_W-1:0]   fill_inc;

    assign cmd_ready = !lim.busy && (!out_valid_reg || out_ready);
    assign take      = cmd_valid && cmd_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        latch_next     = latch_reg;
        exp_next       = exp_reg;
        init_next      = init_reg;
        accepted_next  = accepted_reg;
        chan_next      = chan_reg;
        active_next    = active_reg;
        fill_next      = fill_reg;
        base_next      = base_reg;
        rows_done_next = rows_done_reg;
        res_valid      = 1'b0;
        out_data_next  = out_data_reg;

        c        = chan_reg;
        cnt      = {latch_reg, cmd.byte_value};
        q_ok     = (cmd.byte_value == iqfrd_pkg::CHAN_CODE_Q) && (rows_done_reg[1] < lim.rows);
        i_ok     = (cmd.byte_value == iqfrd_pkg::CHAN_CODE_I) && (rows_done_reg[0] < lim.rows);
        fill_inc = fill_reg[c] + iqfrd_pkg::LEN_W'(1);

        if (take)
        begin
            if (cmd.kind == iqfrd_pkg::CMD_START)
            begin
                latch_next     = '0;
                exp_next       = '0;
                init_next      = 1'b0;
                accepted_next  = 1'b0;
                chan_next      = 1'b0;
                active_next    = 1'b1;
                fill_next      = '{default: '0};
                base_next      = '{default: '0};
                rows_done_next = '{default: '0};
            end
            else if (active_reg)
            begin
                unique case (cmd.kind)
                    iqfrd_pkg::CMD_FRAME:
                    begin
                        accepted_next = 1'b0;
                    end
                    iqfrd_pkg::CMD_COUNT_HI:
                    begin
                        latch_next = cmd.byte_value;
                    end
                    iqfrd_pkg::CMD_COUNT_LO:
                    begin
                        if (!init_reg)
                        begin
                            init_next     = 1'b1;
                            exp_next      = cnt;
                            accepted_next = 1'b1;
                        end
                        else
                        begin
                            accepted_next = (cnt == exp_reg);
                        end
                    end
                    iqfrd_pkg::CMD_CHANNEL:
                    begin
                        if (accepted_reg)
                        begin
                            if (q_ok || i_ok)
                            begin
                                chan_next = q_ok;
                                exp_next  = exp_reg + iqfrd_pkg::COUNT_W'(1);
                            end
                            else
                            begin
                                accepted_next               = 1'b0;
                                active_next                 = 1'b0;
                                res_valid                   = 1'b1;
                                out_data_next.event_kind    = iqfrd_pkg::EVT_ERROR;
                                out_data_next.buffer_select =
                                    (cmd.byte_value == iqfrd_pkg::CHAN_CODE_Q);
                                out_data_next.write_address = '0;
                                out_data_next.data_value    = cmd.byte_value;
                                out_data_next.capture_done  = 1'b0;
                            end
                        end
                    end
                    iqfrd_pkg::CMD_PAYLOAD:
                    begin
                        if (accepted_reg)
                        begin
                            if (rows_done_reg[c] >= lim.rows)
                            begin
                                accepted_next = 1'b0;
                            end
                            else
                            begin
                                res_valid                   = 1'b1;
                                out_data_next.event_kind    = iqfrd_pkg::EVT_WRITE;
                                out_data_next.buffer_select = c;
                                out_data_next.write_address = base_reg[c] +
                                    iqfrd_pkg::ADDR_W'(fill_reg[c]);
                                out_data_next.data_value    = cmd.byte_value;
                                out_data_next.capture_done  = 1'b0;
                                fill_next[c]                = fill_inc;
                                if (fill_inc >= lim.len)
                                begin
                                    rows_done_next[c] = rows_done_reg[c] + iqfrd_pkg::LEN_W'(1);
                                    base_next[c]      = base_reg[c] + iqfrd_pkg::ADDR_W'(lim.len);
                                    fill_next[c]      = '0;
                                    accepted_next     = 1'b0;
                                    if ((rows_done_next[0] >= lim.rows) &&
                                        (rows_done_next[1] >= lim.rows))
                                    begin
                                        out_data_next.capture_done = 1'b1;
                                        active_next                = 1'b0;
                                    end
                                end
                            end
                        end
                    end
                    default:
                    begin
                        accepted_next = accepted_reg;
                    end
                endcase
            end
        end

        if (res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_reg     <= '0;
            exp_reg       <= '0;
            init_reg      <= 1'b0;
            accepted_reg  <= 1'b0;
            chan_reg      <= 1'b0;
            active_reg    <= 1'b0;
            fill_reg      <= '{default: '0};
            base_reg      <= '{default: '0};
            rows_done_reg <= '{default: '0};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            latch_reg     <= latch_next;
            exp_reg       <= exp_next;
            init_reg      <= init_next;
            accepted_reg  <= accepted_next;
            chan_reg      <= chan_next;
            active_reg    <= active_next;
            fill_reg      <= fill_next;
            base_reg      <= base_next;
            rows_done_reg <= rows_done_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* design/iq_frame_row_demux.sv */
// channel   direction  handshake              payload
// in        sink       in_valid / in_ready    in_item_t  (opcode, packet_start, byte)
// out       source     out_valid / out_ready  out_item_t (buffer write or channel error)
// cfg       sink       cfg_en                 cfg_index, cfg_data (row_length, row_count)
//
// One byte per cycle while the queue has room; a result passes the queue and the output register.
// The front tracks the byte position and feeds a four-entry command queue to the back,
// which retires one command per cycle while the output register is free or being taken.
// A configuration write runs a bit-serial divide for the rows that fit the buffer; the back
// holds while it runs, and the front keeps accepting until the queue is full.
// Reset is asynchronous and clears all control state at once; no clearing pass.
`include "iq_frame_row_demux_assert.svh"

module iq_frame_row_demux (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  iqfrd_pkg::in_item_t           in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output iqfrd_pkg::out_item_t          out_data,
    input  logic                          cfg_en,
    input  logic                          cfg_index,
    input  logic [iqfrd_pkg::LEN_W-1:0]   cfg_data
);

    iqfrd_pkg::limits_t lim;
    iqfrd_pkg::cmd_t    push_cmd;
    iqfrd_pkg::cmd_t    cmd;
    logic               push;
    logic               q_full;
    logic               cmd_valid;
    logic               cmd_ready;

    iqfrd_limits u_limits (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_en    (cfg_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .lim       (lim)
    );

    iqfrd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_data  (in_data),
        .q_full   (q_full),
        .in_ready (in_ready),
        .push     (push),
        .push_cmd (push_cmd)
    );

    iqfrd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop_ready (cmd_ready),
        .full      (q_full),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    iqfrd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .lim       (lim),
        .out_ready (out_ready),
        .cmd_ready (cmd_ready),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    `IQFRD_ASSERT_NEXT(a_cfg_starts_divide, cfg_en, lim.busy, "divide did not start after write")
    `IQFRD_ASSERT_NOW(a_hold_while_divide, lim.busy, !cmd_ready, "back ran during divide")
    `IQFRD_ASSERT_NOW(a_error_fields, out_valid && (out_data.event_kind == iqfrd_pkg::EVT_ERROR), (out_data.write_address == '0) && !out_data.capture_done, "malformed error result")

endmodule

/* tb/iq_frame_row_demux_test.sv */
`timescale 1ns / 100ps

module iq_frame_row_demux_test;
    import iqfrd_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_OFF     = 64;
    localparam int RANDOM_ITEMS = 100;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    in_item_t             in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_item_t            out_data;
    logic                 cfg_en    = 1'b0;
    logic                 cfg_index = CFG_ROW_LENGTH;
    logic [LEN_W-1:0]     cfg_data  = '0;

    iq_frame_row_demux dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_en    (cfg_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    out_item_t           expected_events[$];
    int                  failures     = 0;
    int                  cycles       = 0;
    int                  items_sent   = 0;
    int                  in_quiet     = 0;
    int                  out_quiet    = 0;

    logic [LEN_W-1:0]    len_reg;
    logic [LEN_W-1:0]    rows_reg;
    logic [POS_W-1:0]    pos_ctr;
    logic [BYTE_W-1:0]   count_msb;
    logic [COUNT_W-1:0]  next_frame_no;
    bit                  frame_no_seen;
    bit                  frame_taken;
    bit                  frame_buf;
    logic [LEN_W-1:0]    fill[2];
    logic [ADDR_W-1:0]   row_base[2];
    logic [LEN_W-1:0]    full_rows[2];
    bit                  capturing;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL iq_frame_row_demux");
            $finish;
        end
    end

    function automatic int draw_gap(inout int quiet_left);
        if (quiet_left > 0)
        begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            quiet_left = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    function automatic in_item_t make_request(input logic op, input logic first,
                                              input logic [BYTE_W-1:0] value);
        in_item_t req;
        req.opcode       = op;
        req.packet_start = first;
        req.byte_value   = value;
        return req;
    endfunction

    function automatic int row_bytes();
        int n = len_reg;
        if (n < 1)
            n = 1;
        if (n > LEN_MAX)
            n = LEN_MAX;
        return n;
    endfunction

    function automatic int row_goal();
        int fit = BUFFER_BYTES / row_bytes();
        int r   = rows_reg;
        if (r < 1)
            r = 1;
        if (r > fit)
            r = fit;
        return r;
    endfunction

    function automatic void clear_demux_state();
        pos_ctr       = '0;
        count_msb     = '0;
        next_frame_no = '0;
        frame_no_seen = 1'b0;
        frame_taken   = 1'b0;
        frame_buf     = 1'b0;
        for (int c = 0; c < 2; c++)
        begin
            fill[c]      = '0;
            row_base[c]  = '0;
            full_rows[c] = '0;
        end
        capturing     = 1'b0;
    endfunction

    function automatic void route_byte(input in_item_t req);
        int                 pos;
        int                 len;
        int                 rows;
        int                 c;
        logic [COUNT_W-1:0] number;
        out_item_t          ev;
        ev = '0;
        if (req.opcode)
        begin
            clear_demux_state();
            pos_ctr   = PAYLOAD_POS;
            capturing = 1'b1;
            return;
        end
        if (!capturing)
            return;
        pos = req.packet_start ? 0 : int'(pos_ctr);
        pos_ctr = (pos + 1 > PAYLOAD_OFFSET) ? PAYLOAD_POS : POS_W'(pos + 1);
        if (req.packet_start)
            frame_taken = 1'b0;
        len  = row_bytes();
        rows = row_goal();
        if (pos == int'(COUNT_HI_POS))
            count_msb = req.byte_value;
        else if (pos == int'(COUNT_LO_POS))
        begin
            number = {count_msb, req.byte_value};
            if (!frame_no_seen)
            begin
                frame_no_seen = 1'b1;
                next_frame_no = number;
            end
            frame_taken = (number == next_frame_no);
        end
        else if (pos == int'(CHANNEL_POS))
        begin
            if (!frame_taken)
                return;
            if (req.byte_value == CHAN_CODE_Q && full_rows[1] < rows)
                c = 1;
            else if (req.byte_value == CHAN_CODE_I && full_rows[0] < rows)
                c = 0;
            else
                c = -1;
            if (c < 0)
            begin
                frame_taken      = 1'b0;
                capturing        = 1'b0;
                ev.event_kind    = EVT_ERROR;
                ev.buffer_select = (req.byte_value == CHAN_CODE_Q);
                ev.data_value    = req.byte_value;
                expected_events.push_back(ev);
            end
            else
            begin
                frame_buf     = c[0];
                next_frame_no = next_frame_no + 1'b1;
            end
        end
        else if (pos >= PAYLOAD_OFFSET && frame_taken)
        begin
            c = frame_buf;
            if (full_rows[c] >= rows)
            begin
                frame_taken = 1'b0;
                return;
            end
            ev.event_kind    = EVT_WRITE;
            ev.buffer_select = frame_buf;
            ev.write_address = row_base[c] + ADDR_W'(fill[c]);
            ev.data_value    = req.byte_value;
            fill[c] = fill[c] + 1'b1;
            if (fill[c] >= len)
            begin
                full_rows[c] = full_rows[c] + 1'b1;
                row_base[c]  = row_base[c] + ADDR_W'(len);
                fill[c]      = '0;
                frame_taken  = 1'b0;
                if (full_rows[0] >= rows && full_rows[1] >= rows)
                begin
                    ev.capture_done = 1'b1;
                    capturing       = 1'b0;
                end
            end
            expected_events.push_back(ev);
        end
    endfunction

    task automatic push_request(input in_item_t req);
        int gap;
        gap = draw_gap(in_quiet);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        route_byte(req);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (HOLD_OFF) @(posedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [LEN_W-1:0] value);
        wait_idle();
        cfg_en    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_en    <= 1'b0;
        if (idx == CFG_ROW_LENGTH)
            len_reg = value;
        else
            rows_reg = value;
    endtask

    task automatic send_frame(input logic [COUNT_W-1:0] number,
                              input logic [BYTE_W-1:0] channel, input int total);
        logic [BYTE_W-1:0] value;
        for (int i = 0; i < total; i++)
        begin
            if (i == int'(COUNT_HI_POS))
                value = number[15:8];
            else if (i == int'(COUNT_LO_POS))
                value = number[7:0];
            else if (i == int'(CHANNEL_POS))
                value = channel;
            else
                value = $urandom_range(0, 255);
            push_request(make_request(1'b0, i == 0, value));
        end
    endtask

    task automatic send_noise(input int n);
        repeat (n)
            push_request(make_request($urandom_range(0, 15) == 0, $urandom_range(0, 1),
                                      $urandom_range(0, 255)));
    endtask

    task automatic start_capture();
        push_request(make_request(1'b1, $urandom_range(0, 1), $urandom_range(0, 255)));
    endtask

    task automatic random_config();
        write_register(CFG_ROW_LENGTH,
                       ($urandom_range(0, 7) == 0) ? '0 : LEN_W'($urandom_range(1, 6)));
        write_register(CFG_ROW_COUNT,
                       ($urandom_range(0, 7) == 0) ? '0 : LEN_W'($urandom_range(1, 3)));
    endtask

    task automatic test_idle_bytes();
        send_frame(16'h0005, CHAN_CODE_I, PAYLOAD_OFFSET + 3);
        push_request(make_request(1'b0, 1'b0, 8'hFF));
    endtask

    task automatic test_capture_rows();
        write_register(CFG_ROW_LENGTH, LEN_W'(4));
        start_capture();
        push_request(make_request(1'b0, 1'b0, 8'h00));
        push_request(make_request(1'b0, 1'b0, 8'hFF));
        send_frame(16'hFFFF, CHAN_CODE_I, PAYLOAD_OFFSET + 6);
        send_frame(16'h0000, CHAN_CODE_Q, PAYLOAD_OFFSET + 4);
    endtask

    task automatic test_frame_faults();
        write_register(CFG_ROW_COUNT, LEN_W'(2));
        start_capture();
        send_frame(16'h1234, CHAN_CODE_Q, PAYLOAD_OFFSET + 2);
        send_frame(16'h1234, CHAN_CODE_Q, PAYLOAD_OFFSET + 2);
        send_frame(16'h1235, CHAN_CODE_I, int'(COUNT_LO_POS));
        send_frame(16'h1235, CHAN_CODE_I, int'(CHANNEL_POS));
        send_frame(16'h1235, CHAN_CODE_Q, PAYLOAD_OFFSET + 6);
        send_frame(16'h1236, 8'h07, PAYLOAD_OFFSET + 2);
        send_frame(16'h1236, CHAN_CODE_I, PAYLOAD_OFFSET + 2);
        write_register(CFG_ROW_LENGTH, LEN_W'(1));
        write_register(CFG_ROW_COUNT, LEN_W'(1));
        start_capture();
        send_frame(16'h0000, CHAN_CODE_I, PAYLOAD_OFFSET + 1);
        send_frame(16'h0001, CHAN_CODE_I, PAYLOAD_OFFSET + 1);
        start_capture();
        send_frame(16'h0007, CHAN_CODE_Q, PAYLOAD_OFFSET + 1);
        push_request(make_request(1'b1, 1'b1, 8'hFF));
        send_frame(16'h0008, CHAN_CODE_Q, PAYLOAD_OFFSET + 1);
        send_frame(16'h0009, CHAN_CODE_Q, PAYLOAD_OFFSET + 2);
    endtask

    task automatic test_register_limits();
        write_register(CFG_ROW_LENGTH, '0);
        write_register(CFG_ROW_COUNT, '0);
        start_capture();
        send_frame(16'hFFFF, CHAN_CODE_I, PAYLOAD_OFFSET + 2);
        send_frame(16'h0000, CHAN_CODE_Q, PAYLOAD_OFFSET + 2);
        write_register(CFG_ROW_LENGTH, 13'h1FFF);
        write_register(CFG_ROW_COUNT, 13'h1FFF);
        start_capture();
        send_frame(16'h0000, CHAN_CODE_I, PAYLOAD_OFFSET + 40);
        send_frame(16'h0001, CHAN_CODE_Q, PAYLOAD_OFFSET + 3);
        write_register(CFG_ROW_LENGTH, LEN_W'(MAX_ROW_BYTES));
        write_register(CFG_ROW_COUNT, LEN_W'(4096));
        start_capture();
        send_frame(16'h00AA, CHAN_CODE_I, PAYLOAD_OFFSET + 20);
        // shrink the row below the current fill while the capture runs
        write_register(CFG_ROW_LENGTH, LEN_W'(8));
        write_register(CFG_ROW_COUNT, LEN_W'(2));
        send_frame(16'h00AB, CHAN_CODE_I, PAYLOAD_OFFSET + 4);
        send_frame(16'h00AC, CHAN_CODE_I, PAYLOAD_OFFSET + 9);
        send_frame(16'h00AD, CHAN_CODE_Q, PAYLOAD_OFFSET + 9);
        send_frame(16'h00AE, CHAN_CODE_Q, PAYLOAD_OFFSET + 9);
    endtask

    task automatic test_random_stream();
        int                 first_item;
        int                 pick;
        int                 plen;
        int                 rows;
        logic [BYTE_W-1:0]  chan;
        logic [COUNT_W-1:0] number;
        first_item = items_sent;
        random_config();
        while (items_sent - first_item < RANDOM_ITEMS)
        begin
            if (!capturing)
            begin
                if ($urandom_range(0, 3) == 0)
                    random_config();
                if ($urandom_range(0, 3) == 0)
                    send_noise($urandom_range(1, 3));
                start_capture();
            end
            else if ($urandom_range(0, 19) == 0)
                random_config();
            rows = row_goal();
            if ($urandom_range(0, 11) == 0)
                chan = $urandom_range(0, 255);
            else if (full_rows[0] >= rows)
                chan = CHAN_CODE_Q;
            else if (full_rows[1] >= rows)
                chan = CHAN_CODE_I;
            else
                chan = $urandom_range(0, 1) ? CHAN_CODE_Q : CHAN_CODE_I;
            number = frame_no_seen ? next_frame_no : COUNT_W'($urandom);
            plen   = $urandom_range(0, ((row_bytes() > 8) ? 8 : row_bytes()) + 3);
            pick   = $urandom_range(0, 9);
            if (pick <= 6)
                send_frame(number, chan, PAYLOAD_OFFSET + plen);
            else if (pick == 7)
                send_frame(number + COUNT_W'($urandom_range(1, 65535)), chan,
                           PAYLOAD_OFFSET + plen);
            else if (pick == 8)
                send_frame(number, chan, $urandom_range(1, int'(CHANNEL_POS)));
            else
                send_noise($urandom_range(1, 4));
        end
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endfunction

    initial
    begin
        out_item_t got;
        out_item_t want;
        int        stall;
        wait (rst_n);
        forever
        begin
            stall = draw_gap(out_quiet);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            got = out_data;
            if (expected_events.size() == 0)
            begin
                $error("unexpected result: kind %0d sel %0d addr %0h data %0h done %0d",
                       got.event_kind, got.buffer_select, got.write_address,
                       got.data_value, got.capture_done);
                failures++;
            end
            else
            begin
                want = expected_events.pop_front();
                check_field("event_kind", want.event_kind, got.event_kind);
                check_field("buffer_select", want.buffer_select, got.buffer_select);
                check_field("write_address", want.write_address, got.write_address);
                check_field("data_value", want.data_value, got.data_value);
                check_field("capture_done", want.capture_done, got.capture_done);
            end
        end
    end

    initial
    begin
        len_reg  = ROW_LENGTH_RESET;
        rows_reg = ROW_COUNT_RESET;
        clear_demux_state();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_bytes();
        test_capture_rows();
        test_frame_faults();
        test_register_limits();
        test_random_stream();
        wait_idle();
        if (failures == 0)
            $display("PASS iq_frame_row_demux");
        else
            $display("FAIL iq_frame_row_demux");
        $finish;
    end

endmodule
